// ----- design/ufpf_pkg.sv -----
// ----------------------------------------------------------------------------
// UDP frame parse filter package
// Shared types and constants for the header parser and verdict logic.
// ----------------------------------------------------------------------------
package ufpf_pkg;

  localparam int CountWidth = 17;
  localparam int LenWidth   = 18;
  localparam int CfgIdxWidth  = 8;
  localparam int CfgDataWidth = 32;

  localparam logic [CountWidth-1:0] COUNT_MAX = '1;

  // Header field byte offsets within the frame.
  localparam logic [CountWidth-1:0] OFF_ETHER_TYPE = 17'd12;
  localparam logic [CountWidth-1:0] OFF_VER_IHL    = 17'd14;
  localparam logic [CountWidth-1:0] OFF_UDP_MIN    = 17'd15;
  localparam logic [CountWidth-1:0] OFF_TOTAL_LEN  = 17'd16;
  localparam logic [CountWidth-1:0] OFF_PROTOCOL   = 17'd23;
  localparam logic [CountWidth-1:0] OFF_IP_SRC     = 17'd26;
  localparam logic [CountWidth-1:0] OFF_IP_DST     = 17'd30;

  localparam logic [6:0]  ETH_HDR_LEN    = 7'd14;
  localparam logic [6:0]  IP_MIN_HDR     = 7'd20;
  localparam logic [6:0]  UDP_HDR_LEN    = 7'd8;
  localparam logic [6:0]  MIN_FRAME_LEN  = 7'd42;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DST_IP_FILTER   = 8'd0,
    REG_DST_PORT_FILTER = 8'd1
  } cfg_reg_t;

  // Header summary of one finished frame, handed from parser to checker.
  typedef struct packed {
    logic [15:0]         ether_type;
    logic [7:0]          version_ihl;
    logic [7:0]          ip_protocol;
    logic [15:0]         ip_total_length;
    logic [31:0]         ip_source;
    logic [31:0]         ip_destination;
    logic [15:0]         udp_source_port;
    logic [15:0]         udp_dest_port;
    logic [15:0]         udp_length;
    logic [LenWidth-1:0] frame_bytes;
  } frame_rec_t;

endpackage

// ----- design/ufpf_ifs.sv -----
// ----------------------------------------------------------------------------
// UDP frame parse filter channel interfaces
// Byte input, verdict output and configuration write channels.
// ----------------------------------------------------------------------------
interface ufpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, data_byte, last, input ready);
  modport sink   (input valid, data_byte, last, output ready);
endinterface

interface ufpf_res_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [31:0] source_ip;
  logic [15:0] source_port;
  logic [15:0] payload_length;
  logic [6:0]  payload_offset;

  modport source (output valid, accepted, source_ip, source_port, payload_length,
                  payload_offset, input ready);
  modport sink   (input valid, accepted, source_ip, source_port, payload_length,
                  payload_offset, output ready);
endinterface

interface ufpf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/ufpf_front.sv -----
// ----------------------------------------------------------------------------
// UDP frame parse filter front end
// Takes one frame byte per word, captures header fields by offset and
// pushes a header summary into the queue on the last byte.
// ----------------------------------------------------------------------------
module ufpf_front
  import ufpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ufpf_byte_if.sink   in_ch,
  input  logic        q_full,
  output logic        q_push,
  output frame_rec_t  q_rec
);

  logic [CountWidth-1:0] byte_count;
  logic [CountWidth-1:0] byte_count_next;
  logic [15:0] ether_type, ether_type_next;
  logic [7:0]  version_ihl, version_ihl_next;
  logic [7:0]  ip_protocol, ip_protocol_next;
  logic [15:0] ip_total_length, ip_total_length_next;
  logic [31:0] ip_source, ip_source_next;
  logic [31:0] ip_destination, ip_destination_next;
  logic [15:0] udp_source_port, udp_source_port_next;
  logic [15:0] udp_dest_port, udp_dest_port_next;
  logic [15:0] udp_length, udp_length_next;
  logic [6:0]  udp_base;
  logic [CountWidth-1:0] udp_k;
  logic        accept;
  logic [7:0]  b;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  // The UDP header follows the IP header, whose size comes from the IHL
  // captured earlier in this frame.
  assign udp_base = ETH_HDR_LEN + {1'b0, version_ihl[3:0], 2'b00};
  assign udp_k    = byte_count - CountWidth'(udp_base);

  always_comb begin
    ether_type_next      = ether_type;
    version_ihl_next     = version_ihl;
    ip_protocol_next     = ip_protocol;
    ip_total_length_next = ip_total_length;
    ip_source_next       = ip_source;
    ip_destination_next  = ip_destination;
    udp_source_port_next = udp_source_port;
    udp_dest_port_next   = udp_dest_port;
    udp_length_next      = udp_length;

    unique case (byte_count)
      OFF_ETHER_TYPE:           ether_type_next[15:8]      = b;
      OFF_ETHER_TYPE + 17'd1:   ether_type_next[7:0]       = b;
      OFF_VER_IHL:              version_ihl_next           = b;
      OFF_TOTAL_LEN:            ip_total_length_next[15:8] = b;
      OFF_TOTAL_LEN + 17'd1:    ip_total_length_next[7:0]  = b;
      OFF_PROTOCOL:             ip_protocol_next           = b;
      OFF_IP_SRC:               ip_source_next[31:24]      = b;
      OFF_IP_SRC + 17'd1:       ip_source_next[23:16]      = b;
      OFF_IP_SRC + 17'd2:       ip_source_next[15:8]       = b;
      OFF_IP_SRC + 17'd3:       ip_source_next[7:0]        = b;
      OFF_IP_DST:               ip_destination_next[31:24] = b;
      OFF_IP_DST + 17'd1:       ip_destination_next[23:16] = b;
      OFF_IP_DST + 17'd2:       ip_destination_next[15:8]  = b;
      OFF_IP_DST + 17'd3:       ip_destination_next[7:0]   = b;
      default: ;
    endcase

    if (byte_count >= OFF_UDP_MIN && byte_count >= CountWidth'(udp_base) &&
        udp_k < 17'd6) begin
      unique case (udp_k[2:0])
        3'd0:    udp_source_port_next[15:8] = b;
        3'd1:    udp_source_port_next[7:0]  = b;
        3'd2:    udp_dest_port_next[15:8]   = b;
        3'd3:    udp_dest_port_next[7:0]    = b;
        3'd4:    udp_length_next[15:8]      = b;
        3'd5:    udp_length_next[7:0]       = b;
        default: ;
      endcase
    end

    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 17'd1;
  end

  // The summary includes whatever the last byte itself contributes.
  always_comb begin
    q_push                = accept && in_ch.last;
    q_rec.ether_type      = ether_type_next;
    q_rec.version_ihl     = version_ihl_next;
    q_rec.ip_protocol     = ip_protocol_next;
    q_rec.ip_total_length = ip_total_length_next;
    q_rec.ip_source       = ip_source_next;
    q_rec.ip_destination  = ip_destination_next;
    q_rec.udp_source_port = udp_source_port_next;
    q_rec.udp_dest_port   = udp_dest_port_next;
    q_rec.udp_length      = udp_length_next;
    q_rec.frame_bytes     = {1'b0, byte_count} + 18'd1;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_ch.last)) begin
      byte_count      <= '0;
      ether_type      <= '0;
      version_ihl     <= '0;
      ip_protocol     <= '0;
      ip_total_length <= '0;
      ip_source       <= '0;
      ip_destination  <= '0;
      udp_source_port <= '0;
      udp_dest_port   <= '0;
      udp_length      <= '0;
    end else if (accept) begin
      byte_count      <= byte_count_next;
      ether_type      <= ether_type_next;
      version_ihl     <= version_ihl_next;
      ip_protocol     <= ip_protocol_next;
      ip_total_length <= ip_total_length_next;
      ip_source       <= ip_source_next;
      ip_destination  <= ip_destination_next;
      udp_source_port <= udp_source_port_next;
      udp_dest_port   <= udp_dest_port_next;
      udp_length      <= udp_length_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.last |=> byte_count == '0 && version_ihl == '0)
    else $error("frame state not cleared after last word");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept && !in_ch.last && byte_count != COUNT_MAX |=>
      byte_count == $past(byte_count) + 17'd1)
    else $error("byte counter did not advance");

  a_fresh_frame: assert property (@(posedge clk) disable iff (rst)
    byte_count == '0 |-> ether_type == '0 && udp_length == '0 && ip_source == '0)
    else $error("stale header fields at frame start");

endmodule

// ----- design/ufpf_queue.sv -----
// ----------------------------------------------------------------------------
// UDP frame parse filter summary queue
// Short FIFO of header summaries between the parser and the checker.
// ----------------------------------------------------------------------------
module ufpf_queue
  import ufpf_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_rec_t push_rec,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output frame_rec_t head_rec
);

  localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntWidth = $clog2(Depth + 1);

  frame_rec_t          entries [Depth];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;

  assign full     = (count == CntWidth'(Depth));
  assign empty    = (count == '0);
  assign head_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PtrWidth'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PtrWidth'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/ufpf_back.sv -----
// ----------------------------------------------------------------------------
// UDP frame parse filter back end
// Holds the filter registers, checks one header summary per cycle while the output register is free, and
// registers the verdict toward the output channel.
// ----------------------------------------------------------------------------
module ufpf_back
  import ufpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ufpf_cfg_if.sink    cfg,
  input  logic        q_empty,
  input  frame_rec_t  q_head,
  output logic        q_pop,
  ufpf_res_if.source  out_ch
);

  logic [31:0] dst_ip_filter;
  logic [15:0] dst_port_filter;
  logic [6:0]  hdr_len;
  logic [6:0]  pay_off;
  logic        ok;
  logic        out_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_ip_filter   <= '0;
      dst_port_filter <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_DST_IP_FILTER) begin
        dst_ip_filter <= cfg.data;
      end else if (cfg.index == REG_DST_PORT_FILTER) begin
        dst_port_filter <= cfg.data[15:0];
      end
    end
  end

  assign hdr_len = {1'b0, q_head.version_ihl[3:0], 2'b00};
  assign pay_off = ETH_HDR_LEN + hdr_len + UDP_HDR_LEN;

  always_comb begin
    ok = (q_head.frame_bytes >= LenWidth'(MIN_FRAME_LEN)) &&
         (q_head.ether_type == ETHERTYPE_IPV4) &&
         (q_head.version_ihl[7:4] == IP_VERSION_4) &&
         (hdr_len >= IP_MIN_HDR) &&
         (q_head.ip_protocol == PROTO_UDP) &&
         (dst_ip_filter == '0 || q_head.ip_destination == dst_ip_filter) &&
         ({2'b00, q_head.ip_total_length} + LenWidth'(ETH_HDR_LEN) <=
           q_head.frame_bytes) &&
         (LenWidth'(pay_off) <= q_head.frame_bytes) &&
         (dst_port_filter == '0 || q_head.udp_dest_port == dst_port_filter) &&
         (q_head.udp_length >= 16'(UDP_HDR_LEN));
  end

  assign out_free = !out_ch.valid || out_ch.ready;
  assign q_pop    = !q_empty && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_free) begin
      out_ch.valid <= !q_empty;
    end
  end

  // A rejected frame reports all payload fields as zero.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_ch.accepted       <= ok;
      out_ch.source_ip      <= ok ? q_head.ip_source : '0;
      out_ch.source_port    <= ok ? q_head.udp_source_port : '0;
      out_ch.payload_length <= ok ? q_head.udp_length - 16'(UDP_HDR_LEN) : '0;
      out_ch.payload_offset <= ok ? pay_off : '0;
    end
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.accepted |->
      out_ch.source_ip == '0 && out_ch.source_port == '0 &&
      out_ch.payload_length == '0 && out_ch.payload_offset == '0)
    else $error("rejected word carries nonzero fields");

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> out_ch.valid)
    else $error("popped summary did not reach the output register");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.accepted |->
      out_ch.payload_offset >= MIN_FRAME_LEN && out_ch.payload_length <= 16'd65527)
    else $error("accepted word has impossible offset or length");

endmodule

// ----- design/udp_frame_parse_filter.sv -----
// ----------------------------------------------------------------------------
// UDP frame parse filter
// Parses Ethernet/IPv4/UDP headers from a byte stream and gives one
// verdict word per frame, filtered by destination address and port.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per cycle while the summary queue is not full, including across frames.
// The summary enters the queue at the edge that takes the last byte and moves
// into the output register, which gives the verdict word, once that register is free.
// The summary queue of QueueDepth entries absorbs output stalls; input stalls
// only when it is full. Synchronous reset clears all frame state, the filters
// (to zero, meaning no filtering) and the queue; no clearing pass is needed.
module udp_frame_parse_filter
  import ufpf_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic        clk,
  input  logic        rst,
  ufpf_byte_if.sink   in_ch,
  ufpf_res_if.source  out_ch,
  ufpf_cfg_if.sink    cfg
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  frame_rec_t q_in_rec;
  frame_rec_t q_head;

  ufpf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_rec  (q_in_rec)
  );

  ufpf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (q_in_rec),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_rec (q_head)
  );

  ufpf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- tb/ufpf_verdict_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UDP frame parse filter verdict scoreboard
// Mirrors the header capture and the end-of-frame checks of the parser. Every
// accepted byte updates the mirror, and a byte with the last mark queues the
// verdict word that the block has to return.
// ----------------------------------------------------------------------------
package ufpf_verdict_pkg;
  import ufpf_pkg::*;

  localparam int unsigned EthHdrBytes   = 14;
  localparam int unsigned IpMinHdrBytes = 20;
  localparam int unsigned UdpHdrBytes   = 8;
  localparam int unsigned MinFrameBytes = EthHdrBytes + IpMinHdrBytes + UdpHdrBytes;
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [3:0]  IpVersion4    = 4'd4;
  localparam logic [7:0]  ProtoUdp      = 8'd17;

  // Byte positions of the captured header fields.
  localparam int unsigned PosEtherType = 12;
  localparam int unsigned PosVerIhl    = 14;
  localparam int unsigned PosUdpFirst  = 15;
  localparam int unsigned PosTotalLen  = 16;
  localparam int unsigned PosProtocol  = 23;
  localparam int unsigned PosSrcIp     = 26;
  localparam int unsigned PosDstIp     = 30;

  localparam logic [16:0] ByteCountMax = '1;
  localparam int MaxReported = 10;

  typedef struct packed {
    logic        accepted;
    logic [31:0] source_ip;
    logic [15:0] source_port;
    logic [15:0] payload_length;
    logic [6:0]  payload_offset;
  } verdict_t;

  class verdict_board;
    logic [31:0] ip_filter       = '0;
    logic [15:0] port_filter     = '0;
    logic [16:0] byte_count      = '0;
    logic [15:0] ether_type      = '0;
    logic [7:0]  version_ihl     = '0;
    logic [7:0]  ip_protocol     = '0;
    logic [15:0] ip_total_length = '0;
    logic [31:0] ip_source       = '0;
    logic [31:0] ip_destination  = '0;
    logic [15:0] udp_source_port = '0;
    logic [15:0] udp_dest_port   = '0;
    logic [15:0] udp_length      = '0;
    verdict_t    due_verdicts[$];
    int          mismatches      = 0;
    int          frames_accepted = 0;
    int          frames_rejected = 0;

    function void clear_frame();
      byte_count      = '0;
      ether_type      = '0;
      version_ihl     = '0;
      ip_protocol     = '0;
      ip_total_length = '0;
      ip_source       = '0;
      ip_destination  = '0;
      udp_source_port = '0;
      udp_dest_port   = '0;
      udp_length      = '0;
    endfunction

    function void write_reg(logic [7:0] index, logic [31:0] data);
      if (index == REG_DST_IP_FILTER) begin
        ip_filter = data;
      end else if (index == REG_DST_PORT_FILTER) begin
        port_filter = data[15:0];
      end
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int unsigned idx, base, k, n, hdr_len, off;
      bit ok;
      verdict_t v;
      idx  = byte_count;
      // The UDP header position follows the IHL captured so far.
      base = EthHdrBytes + 4 * version_ihl[3:0];
      if (idx == PosEtherType) begin
        ether_type[15:8] = b;
      end else if (idx == PosEtherType + 1) begin
        ether_type[7:0] = b;
      end else if (idx == PosVerIhl) begin
        version_ihl = b;
      end else if (idx == PosTotalLen) begin
        ip_total_length[15:8] = b;
      end else if (idx == PosTotalLen + 1) begin
        ip_total_length[7:0] = b;
      end else if (idx == PosProtocol) begin
        ip_protocol = b;
      end else if (idx >= PosSrcIp && idx < PosSrcIp + 4) begin
        ip_source[8 * (PosSrcIp + 3 - idx) +: 8] = b;
      end else if (idx >= PosDstIp && idx < PosDstIp + 4) begin
        ip_destination[8 * (PosDstIp + 3 - idx) +: 8] = b;
      end
      if (idx >= PosUdpFirst && idx >= base && idx - base < 6) begin
        k = idx - base;
        unique case (k)
          0: udp_source_port[15:8] = b;
          1: udp_source_port[7:0]  = b;
          2: udp_dest_port[15:8]   = b;
          3: udp_dest_port[7:0]    = b;
          4: udp_length[15:8]      = b;
          default: udp_length[7:0] = b;
        endcase
      end
      if (byte_count != ByteCountMax) byte_count++;
      if (!last) return;

      n       = idx + 1;
      hdr_len = 4 * version_ihl[3:0];
      off     = EthHdrBytes + hdr_len + UdpHdrBytes;
      ok = n >= MinFrameBytes && ether_type == EtherTypeIpv4
        && version_ihl[7:4] == IpVersion4 && hdr_len >= IpMinHdrBytes
        && ip_protocol == ProtoUdp
        && (ip_filter == '0 || ip_destination == ip_filter)
        && EthHdrBytes + ip_total_length <= n && off <= n
        && (port_filter == '0 || udp_dest_port == port_filter)
        && udp_length >= UdpHdrBytes;
      v = '0;
      if (ok) begin
        v.accepted       = 1'b1;
        v.source_ip      = ip_source;
        v.source_port    = udp_source_port;
        v.payload_length = udp_length - 16'(UdpHdrBytes);
        v.payload_offset = 7'(off);
        frames_accepted++;
      end else begin
        frames_rejected++;
      end
      due_verdicts.insert(due_verdicts.size(), v);
      clear_frame();
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (due_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected verdict word: acc=%0b ip=%h port=%h len=%0d off=%0d",
                   got.accepted, got.source_ip, got.source_port, got.payload_length,
                   got.payload_offset);
        return;
      end
      want = due_verdicts.pop_front();
      if (got.accepted !== want.accepted || got.source_ip !== want.source_ip
          || got.source_port !== want.source_port
          || got.payload_length !== want.payload_length
          || got.payload_offset !== want.payload_offset) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("verdict mismatch: expected acc=%0b ip=%h port=%h len=%0d off=%0d",
                   want.accepted, want.source_ip, want.source_port, want.payload_length,
                   want.payload_offset);
          $display("                  actual   acc=%0b ip=%h port=%h len=%0d off=%0d",
                   got.accepted, got.source_ip, got.source_port, got.payload_length,
                   got.payload_offset);
        end
      end
    endfunction
  endclass

endpackage

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UDP frame parse filter testbench
// Streams directed and random Ethernet frames (well-formed UDP frames, frames
// with one broken header field, and raw noise) through the parser under
// several filter settings, with random gaps on both sides and one long output
// stall, and checks every verdict word against the scoreboard.
// ----------------------------------------------------------------------------
module tb;
  import ufpf_pkg::*;
  import ufpf_verdict_pkg::*;

  localparam int HoldCycles     = 200;
  localparam int StallLimit     = 2000;
  localparam int DrainCycles    = 8;
  localparam int ItemTarget     = 1400;
  localparam int MinPhases      = 5;

  typedef struct {
    logic [15:0] ether_type;
    logic [7:0]  version_ihl;
    logic [15:0] total_len;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] udp_sport;
    logic [15:0] udp_dport;
    logic [15:0] udp_len;
    int          wire_len;
  } frame_spec_t;

  typedef enum int {
    FLAW_ETHER_TYPE,
    FLAW_VERSION,
    FLAW_SHORT_IHL,
    FLAW_PROTOCOL,
    FLAW_DST_IP,
    FLAW_TOTAL_LEN,
    FLAW_CUT_UDP,
    FLAW_DST_PORT,
    FLAW_UDP_LEN,
    FLAW_RUNT,
    FLAW_COUNT
  } flaw_t;

  logic clk;
  logic rst;

  ufpf_byte_if in_ch ();
  ufpf_res_if  out_ch ();
  ufpf_cfg_if  cfg ();

  udp_frame_parse_filter u_top (
    .clk,
    .rst,
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  verdict_board board = new();

  bit tx_idle_on    = 1'b1;
  bit rx_idle_on    = 1'b1;
  int hold_requests = 0;
  int holds_done    = 0;
  int bytes_sent    = 0;
  int reg_writes    = 0;
  int input_stalls  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && !in_ch.ready) input_stalls++;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last      <= last;
    do @(posedge clk); while (!in_ch.ready);
    board.take_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] frame[$]);
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic write_reg(input logic [7:0] index, input logic [31:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    board.write_reg(index, data);
    reg_writes++;
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drops valid and lets the block drain before the filters change.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.due_verdicts.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic void put_bytes(ref logic [7:0] frame[$], input int pos,
                                    input logic [31:0] value, input int width);
    for (int i = 0; i < width; i++) begin
      if (pos + i < frame.size()) frame[pos + i] = value[8 * (width - 1 - i) +: 8];
    end
  endfunction

  function automatic void lay_out(input frame_spec_t s, ref logic [7:0] frame[$]);
    int base;
    frame = {};
    for (int i = 0; i < s.wire_len; i++) frame = {frame, 8'($urandom)};
    put_bytes(frame, PosEtherType, 32'(s.ether_type), 2);
    put_bytes(frame, PosVerIhl, 32'(s.version_ihl), 1);
    put_bytes(frame, PosTotalLen, 32'(s.total_len), 2);
    put_bytes(frame, PosProtocol, 32'(s.protocol), 1);
    put_bytes(frame, PosSrcIp, s.src_ip, 4);
    put_bytes(frame, PosDstIp, s.dst_ip, 4);
    // With a short IHL the UDP header would land on the IP header; leave it random.
    if (s.version_ihl[3:0] >= 4'd5) begin
      base = EthHdrBytes + 4 * s.version_ihl[3:0];
      put_bytes(frame, base, 32'(s.udp_sport), 2);
      put_bytes(frame, base + 2, 32'(s.udp_dport), 2);
      put_bytes(frame, base + 4, 32'(s.udp_len), 2);
    end
  endfunction

  function automatic frame_spec_t good_spec();
    frame_spec_t s;
    int ihl, payload;
    ihl     = ($urandom_range(0, 2) == 0) ? $urandom_range(6, 15) : 5;
    payload = $urandom_range(0, 24);
    s.ether_type  = EtherTypeIpv4;
    s.version_ihl = {IpVersion4, 4'(ihl)};
    s.protocol    = ProtoUdp;
    s.src_ip      = $urandom;
    s.udp_sport   = 16'($urandom);
    s.dst_ip      = (board.ip_filter != '0) ? board.ip_filter : 32'($urandom);
    s.udp_dport   = (board.port_filter != '0) ? board.port_filter : 16'($urandom);
    s.wire_len    = EthHdrBytes + 4 * ihl + UdpHdrBytes + payload + $urandom_range(0, 4);
    if (s.wire_len < MinFrameBytes) s.wire_len = MinFrameBytes;
    s.total_len   = 16'($urandom_range(0, s.wire_len - EthHdrBytes));
    s.udp_len     = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(UdpHdrBytes, 65535))
                                                : 16'(UdpHdrBytes + payload);
    return s;
  endfunction

  function automatic void break_spec(ref frame_spec_t s, input flaw_t flaw);
    int off;
    unique case (flaw)
      FLAW_ETHER_TYPE: do s.ether_type = 16'($urandom); while (s.ether_type == EtherTypeIpv4);
      FLAW_VERSION:    do s.version_ihl[7:4] = 4'($urandom);
                       while (s.version_ihl[7:4] == IpVersion4);
      FLAW_SHORT_IHL:  s.version_ihl[3:0] = 4'($urandom_range(0, 4));
      FLAW_PROTOCOL:   do s.protocol = 8'($urandom); while (s.protocol == ProtoUdp);
      FLAW_DST_IP:     do s.dst_ip = $urandom; while (s.dst_ip == board.ip_filter);
      FLAW_TOTAL_LEN:  s.total_len = 16'($urandom_range(s.wire_len - EthHdrBytes + 1, 65535));
      FLAW_CUT_UDP: begin
        // The frame ends before the payload start but is not a runt.
        s.version_ihl[3:0] = 4'($urandom_range(6, 15));
        off         = EthHdrBytes + 4 * s.version_ihl[3:0] + UdpHdrBytes;
        s.wire_len  = $urandom_range(MinFrameBytes, off - 1);
        s.total_len = 16'($urandom_range(0, s.wire_len - EthHdrBytes));
      end
      FLAW_DST_PORT:   do s.udp_dport = 16'($urandom); while (s.udp_dport == board.port_filter);
      FLAW_UDP_LEN:    s.udp_len = 16'($urandom_range(0, UdpHdrBytes - 1));
      default:         s.wire_len = $urandom_range(1, MinFrameBytes - 1);
    endcase
  endfunction

  task automatic send_spec(input frame_spec_t s);
    logic [7:0] frame[$];
    lay_out(s, frame);
    send_frame(frame);
  endtask

  task automatic send_noise(input int len, input bit fixed, input logic [7:0] fill);
    logic [7:0] frame[$];
    for (int i = 0; i < len; i++) frame = {frame, (fixed ? fill : 8'($urandom))};
    send_frame(frame);
  endtask

  task automatic send_random_frame();
    frame_spec_t s;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_noise($urandom_range(1, 60), 1'b0, 8'h00);
    end else begin
      s = good_spec();
      if (pick < 45) break_spec(s, flaw_t'($urandom_range(0, FLAW_COUNT - 1)));
      send_spec(s);
    end
  endtask

  // Output side: random ready gaps, plus a long hold-off whenever one is requested.
  initial begin : verdict_sink
    verdict_t got;
    int gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (holds_done != hold_requests) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        holds_done++;
      end
      gap = rx_idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.accepted       = out_ch.accepted;
      got.source_ip      = out_ch.source_ip;
      got.source_port    = out_ch.source_port;
      got.payload_length = out_ch.payload_length;
      got.payload_offset = out_ch.payload_offset;
      board.check_verdict(got);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg.valid && cfg.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("udp_frame_parse_filter test failed");
    $finish;
  end

  initial begin : stimulus
    frame_spec_t s;
    logic [31:0] ip_sel;
    logic [15:0] port_sel;
    int phase, random_frames;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last      <= 1'b0;
    cfg.valid       <= 1'b0;
    cfg.index       <= '0;
    cfg.data        <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames with both filters off.
    send_spec(good_spec());
    send_noise(1, 1'b0, 8'h00);
    send_noise(MinFrameBytes, 1'b1, 8'hFF);
    send_noise(MinFrameBytes, 1'b1, 8'h00);
    for (int f = 0; f < FLAW_COUNT; f++) begin
      s = good_spec();
      break_spec(s, flaw_t'(f));
      send_spec(s);
    end
    s = good_spec();
    s.version_ihl[3:0] = 4'd5;
    s.wire_len  = MinFrameBytes;
    s.total_len = 16'(MinFrameBytes - EthHdrBytes);
    s.udp_len   = 16'(UdpHdrBytes);
    send_spec(s);
    s = good_spec();
    s.udp_len = 16'hFFFF;
    send_spec(s);
    // Largest IHL with the frame ending exactly at the payload start.
    s = good_spec();
    s.version_ihl[3:0] = 4'hF;
    s.wire_len  = EthHdrBytes + 60 + UdpHdrBytes;
    s.total_len = 16'(s.wire_len - EthHdrBytes);
    send_spec(s);
    settle();

    // Directed filter checks, extremes included.
    write_reg(REG_DST_IP_FILTER, 32'hFFFF_FFFF);
    write_reg(REG_DST_PORT_FILTER, 32'h0000_FFFF);
    send_spec(good_spec());
    s = good_spec();
    break_spec(s, FLAW_DST_IP);
    send_spec(s);
    s = good_spec();
    break_spec(s, FLAW_DST_PORT);
    send_spec(s);
    settle();
    write_reg(8'($urandom_range(int'(REG_DST_PORT_FILTER) + 1, (1 << CfgIdxWidth) - 1)),
              $urandom);
    write_reg(REG_DST_IP_FILTER, 32'h0000_0001);
    // Upper data bits are not part of the port filter.
    write_reg(REG_DST_PORT_FILTER, 32'hABCD_0001);
    send_spec(good_spec());
    s = good_spec();
    break_spec(s, FLAW_DST_PORT);
    send_spec(s);
    settle();

    // Random phases, each with its own filter setting and idling mix.
    phase = 0;
    random_frames = 0;
    while (bytes_sent < ItemTarget || phase < MinPhases) begin
      unique case (phase % 5)
        0: begin ip_sel = '0; port_sel = '0; end
        1: begin ip_sel = $urandom; port_sel = '0; end
        2: begin ip_sel = '0; port_sel = 16'($urandom); end
        3: begin ip_sel = '1; port_sel = '1; end
        default: begin ip_sel = $urandom; port_sel = 16'($urandom); end
      endcase
      write_reg(REG_DST_IP_FILTER, ip_sel);
      write_reg(REG_DST_PORT_FILTER, {16'($urandom), port_sel});
      tx_idle_on = (phase % 3) != 2;
      rx_idle_on = (phase % 4) != 3;
      if (phase == 2) begin
        // Short frames against a stalled output fill the summary queue.
        hold_requests++;
        tx_idle_on = 1'b0;
        repeat (24) send_byte(8'($urandom), 1'b1);
        tx_idle_on = 1'b1;
      end
      send_random_frame();
      random_frames++;
      settle();
      phase++;
    end

    settle();
    $display("Checked %0d frames (%0d accepted, %0d rejected) in %0d bytes, %0d of them random,",
             board.frames_accepted + board.frames_rejected, board.frames_accepted,
             board.frames_rejected, bytes_sent, random_frames);
    $display("over %0d filter phases with %0d register writes and %0d input stall cycles.",
             phase, reg_writes, input_stalls);
    if (board.mismatches == 0 && board.due_verdicts.size() == 0) begin
      $display("udp_frame_parse_filter test passed");
    end else begin
      $display("udp_frame_parse_filter test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/ufpf_pkg.sv
design/ufpf_ifs.sv
design/ufpf_front.sv
design/ufpf_queue.sv
design/ufpf_back.sv
design/udp_frame_parse_filter.sv
tb/ufpf_verdict_pkg.sv
tb/tb.sv
